// File: sv/fndl_pkg.sv
`timescale 1ns / 1ps
// shared types, defaults and operation codes for the file-name directory lookup
// no dependencies

package fndl_pkg;

    // default sizes of the directory
    localparam int SLOT_COUNT_DEF       = 64;
    localparam int NAME_BYTES_DEF       = 6;
    localparam int SECTORS_PER_FILE_DEF = 128;

    // configuration register width
    localparam int SECTOR_W = 32;

    // operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    // control shared by every slot cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

// File: sv/fndl_req_if.sv
`timescale 1ns / 1ps
// request channel: operation code and name bytes
// no dependencies

interface fndl_req_if #(
    parameter int NAME_W = 48
);
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [NAME_W-1:0] name;

    modport source (output valid, output operation, output name, input ready);
    modport sink   (input valid, input operation, input name, output ready);
endinterface

// File: sv/fndl_rsp_if.sv
`timescale 1ns / 1ps
// response channel: found and created flags, slot index and start sector
// no dependencies

interface fndl_rsp_if #(
    parameter int SLOT_W = 6
);
    logic              valid;
    logic              ready;
    logic              found;
    logic              created;
    logic [SLOT_W-1:0] slot_index;
    logic [31:0]       start_sector;

    modport source (output valid, output found, output created, output slot_index,
                    output start_sector, input ready);
    modport sink   (input valid, input found, input created, input slot_index,
                    input start_sector, output ready);
endinterface

// File: sv/fndl_cell.sv
`timescale 1ns / 1ps
// one directory slot in the rotating ring of slot cells
// depends on fndl_pkg (t_cell_ctrl)

module fndl_cell #(
    parameter int NAME_W = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fndl_pkg::t_cell_ctrl  i_ctrl,
    input  logic [NAME_W-1:0]     i_d,
    output logic [NAME_W-1:0]     o_q
);

    logic [NAME_W-1:0] r_slot;

    // slot register: cleared by reset or clear, loaded from neighbor on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_slot <= '0;
        end else if (i_ctrl.shift) begin
            r_slot <= i_d;
        end
    end

    assign o_q = r_slot;

endmodule

// File: sv/fndl_match.sv
`timescale 1ns / 1ps
// name compare at the head of the ring: bytewise up to the first zero byte
// no dependencies

module fndl_match #(
    parameter int NAME_BYTES = 6
) (
    input  logic [8*NAME_BYTES-1:0] i_slot,
    input  logic [8*NAME_BYTES-1:0] i_req,
    output logic                    o_match,
    output logic                    o_empty
);

    // walk the bytes until a mismatch or the terminator
    always_comb begin
        logic stop;
        o_match = 1'b1;
        stop    = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (!stop) begin
                if (i_slot[8*k +: 8] != i_req[8*k +: 8]) begin
                    o_match = 1'b0;
                    stop    = 1'b1;
                end else if (i_slot[8*k +: 8] == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
    end

    // a slot is empty when its first byte is zero
    assign o_empty = (i_slot[7:0] == 8'd0);

endmodule

// File: sv/file_name_directory_lookup_top.sv
`timescale 1ns / 1ps
// top level of the file-name directory lookup: ring of slot cells and scan control
// depends on fndl_pkg, fndl_req_if, fndl_rsp_if, fndl_cell, fndl_match
//
//  port      | dir | transfer contents
//  ----------+-----+---------------------------------------------------
//  i_req     | in  | operation, name
//  o_rsp     | out | found, created, slot_index, start_sector
//  i_cfg_*   | in  | partition_base_sector write, no handshake
//
// a lookup or create rotates the slot ring one full turn past a single comparator
// at its head, one slot per cycle, then the result is loaded into the output register.
// a clear empties all cells in the same cycle as its transfer, then responds through the hold state.
// reset empties every slot at once; no clearing pass is needed.
// a stalled response holds the block in its hold state; no new request is taken
// until the result has moved into the output register.

module file_name_directory_lookup_top #(
    parameter int SLOT_COUNT       = fndl_pkg::SLOT_COUNT_DEF,
    parameter int NAME_BYTES       = fndl_pkg::NAME_BYTES_DEF,
    parameter int SECTORS_PER_FILE = fndl_pkg::SECTORS_PER_FILE_DEF,
    localparam int NAME_W          = 8 * NAME_BYTES,
    localparam int SLOT_W          = $clog2(SLOT_COUNT)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fndl_pkg::SECTOR_W-1:0] i_cfg_wdata,
    fndl_req_if.sink                      i_req,
    fndl_rsp_if.source                    o_rsp
);

    localparam logic [SLOT_W-1:0]             LAST_STEP = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [fndl_pkg::SECTOR_W-1:0] SEC_STEP  =
        fndl_pkg::SECTOR_W'(SECTORS_PER_FILE);

    fndl_pkg::t_state r_state, n_state;

    logic [fndl_pkg::SECTOR_W-1:0] r_base;
    logic [1:0]                    r_op;
    logic [NAME_W-1:0]             r_req;
    logic [SLOT_W-1:0]             r_step;
    logic [fndl_pkg::SECTOR_W-1:0] r_sec;
    logic                          r_decided;
    logic                          r_hit;
    logic                          r_made;
    logic [SLOT_W-1:0]             r_idx;
    logic [fndl_pkg::SECTOR_W-1:0] r_sec_hit;

    logic                          r_out_valid;
    logic                          r_out_found;
    logic                          r_out_created;
    logic [SLOT_W-1:0]             r_out_idx;
    logic [fndl_pkg::SECTOR_W-1:0] r_out_sec;

    logic                  w_accept;
    logic                  w_scan;
    logic                  w_last;
    logic                  w_match;
    logic                  w_empty;
    logic                  w_create_now;
    logic                  w_hit_now;
    logic                  w_out_free;
    logic                  w_load_out;
    logic [NAME_W-1:0]     w_tail;
    logic [NAME_W-1:0]     w_q [SLOT_COUNT];
    fndl_pkg::t_cell_ctrl  w_ctrl;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // handshake and scan status
    assign i_req.ready  = (r_state == fndl_pkg::ST_IDLE);
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_scan       = (r_state == fndl_pkg::ST_SCAN);
    assign w_last       = (r_step == LAST_STEP);
    assign w_out_free   = !r_out_valid || o_rsp.ready;
    assign w_load_out   = (r_state == fndl_pkg::ST_HOLD) && w_out_free;

    // compare at the ring head
    fndl_match #(
        .NAME_BYTES (NAME_BYTES)
    ) u_match (
        .i_slot  (w_q[0]),
        .i_req   (r_req),
        .o_match (w_match),
        .o_empty (w_empty)
    );

    assign w_create_now = w_scan && !r_decided && !w_match && w_empty
                          && (r_op == fndl_pkg::OP_CREATE);
    assign w_hit_now    = w_scan && !r_decided && (w_match || w_create_now);

    // ring control: rotate while scanning, clear on a clear request
    assign w_ctrl.shift = w_scan;
    assign w_ctrl.clear = w_accept && (i_req.operation == fndl_pkg::OP_CLEAR);

    // head slot returns to the tail, replaced by the request when a create claims an empty slot
    assign w_tail = w_create_now ? r_req : w_q[0];

    // ring of slot cells, each handing its name to the lower neighbor
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        logic [NAME_W-1:0] w_d;
        if (g == SLOT_COUNT - 1) begin : g_tail
            assign w_d = w_tail;
        end else begin : g_mid
            assign w_d = w_q[g+1];
        end
        fndl_cell #(
            .NAME_W (NAME_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_d     (w_d),
            .o_q     (w_q[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fndl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.operation == fndl_pkg::OP_CLEAR)
                              ? fndl_pkg::ST_HOLD : fndl_pkg::ST_SCAN;
                end
            end
            fndl_pkg::ST_SCAN: begin
                if (w_last) begin
                    n_state = fndl_pkg::ST_HOLD;
                end
            end
            fndl_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    n_state = fndl_pkg::ST_IDLE;
                end
            end
            default: n_state = fndl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fndl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan bookkeeping: step count, running start sector and decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decided <= 1'b0;
            r_hit     <= 1'b0;
            r_made    <= 1'b0;
        end else if (w_accept) begin
            r_decided <= 1'b0;
            r_hit     <= 1'b0;
            r_made    <= 1'b0;
        end else if (w_hit_now) begin
            r_decided <= 1'b1;
            r_hit     <= 1'b1;
            r_made    <= w_create_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.operation;
            r_req  <= i_req.name;
            r_step <= '0;
            r_sec  <= r_base + fndl_pkg::SECTOR_W'(1);
        end else if (w_scan) begin
            r_step <= r_step + SLOT_W'(1);
            r_sec  <= r_sec + SEC_STEP;
        end
        if (w_hit_now) begin
            r_idx     <= r_step;
            r_sec_hit <= r_sec;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_found   <= r_hit;
            r_out_created <= r_made;
            r_out_idx     <= r_hit ? r_idx : '0;
            r_out_sec     <= r_hit ? r_sec_hit : '0;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_out_found;
    assign o_rsp.created      = r_out_created;
    assign o_rsp.slot_index   = r_out_idx;
    assign o_rsp.start_sector = r_out_sec;

`ifndef NO_ASSERTIONS
    // a full ring turn always ends in the hold state
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_scan && w_last) |=> (r_state == fndl_pkg::ST_HOLD))
        else $error("scan did not end in hold");

    // a decision made during a scan is never dropped
    a_decided_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_scan && r_decided) |=> r_decided)
        else $error("scan decision lost");

    // only a create request can write a slot
    a_made_create: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != fndl_pkg::ST_IDLE) && r_made) |-> (r_op == fndl_pkg::OP_CREATE))
        else $error("slot created without create request");

    // a created result is always a found result
    a_created_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.created) |-> o_rsp.found)
        else $error("created without found");

    // a miss carries zero index and sector
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> ((o_rsp.slot_index == '0)
                                           && (o_rsp.start_sector == '0)))
        else $error("miss with nonzero fields");
`endif

endmodule
